// File: rtl/sfs_pkg.sv
// sfs_pkg: shared constants, codes and types of the sprite frame sequencer
// no dependencies; used by sprite_frame_sequencer, sfs_ctrl and sfs_frame_ram, not by sfs_checker
`default_nettype none
package sfs_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int FRAME_W    = 4;
   localparam int COUNT_W    = 5;
   localparam int TILE_W     = 8;
   localparam int TICKS_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_RESTART = 2'd1,
      ACT_PLAY    = 2'd2,
      ACT_WRITE   = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEQ_ACTIVE      = 3'd0,
      CSR_TICKS_PER_FRAME = 3'd1,
      CSR_FRAME_COUNT     = 3'd2,
      CSR_PLAY_MODE       = 3'd3
   } csr_index_type;

   localparam logic [1:0] MODE_LOOP = 2'd1;

   typedef struct packed {
      logic               advanced;
      logic [FRAME_W-1:0] frame;
      logic               finished;
      logic               tile_zero;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/sprite_frame_sequencer.sv
// sprite_frame_sequencer: top level, control update, tile table read, output register
// depends on sfs_pkg, sfs_ctrl, sfs_frame_ram
//
//   channel   direction  ports
//   req       in         req_valid req_stall req_action req_entry_index req_entry_tile
//   rsp       out        rsp_valid rsp_stall rsp_advanced rsp_frame_index rsp_tile_out
//                        rsp_finished
//   csr       in         csr_we csr_index csr_wdata
//
// one word a cycle while the input is not stalled; a result passes through the
// table read stage, where the tile table read is registered, and then the output register
// synchronous reset clears control state and empties the pipeline
// a stalled result holds; input is stalled only when the table read stage is also full
`default_nettype none
module sprite_frame_sequencer (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [sfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [sfs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [1:0]                        req_action,
   input  wire [3:0]                        req_entry_index,
   input  wire [7:0]                        req_entry_tile,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_advanced,
   output logic [3:0]                       rsp_frame_index,
   output logic [7:0]                       rsp_tile_out,
   output logic                             rsp_finished
);

   logic                        accept;
   logic                        move;
   logic [sfs_pkg::FRAME_W-1:0] frame_next;
   logic [sfs_pkg::TILE_W-1:0]  rd_data;
   sfs_pkg::result_type         result;

   logic                        s1_valid_ff, s1_valid_in;
   sfs_pkg::result_type         s1_res_ff;
   logic                        out_valid_ff, out_valid_in;
   sfs_pkg::result_type         out_res_ff;
   logic [sfs_pkg::TILE_W-1:0]  out_tile_ff;

   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign move      = s1_valid_ff && (!out_valid_ff || !rsp_stall);

   sfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .action     (req_action),
      .frame_next (frame_next),
      .result     (result)
   );

   sfs_frame_ram u_ram (
      .clock   (clock),
      .wr_en   (accept && (req_action == sfs_pkg::ACT_WRITE)),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_tile),
      .rd_en   (accept),
      .rd_addr (frame_next),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !move);
      out_valid_in = move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= result;
      end
      if (move) begin
         out_res_ff  <= s1_res_ff;
         out_tile_ff <= s1_res_ff.tile_zero ? '0 : rd_data;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_advanced    = out_res_ff.advanced;
   assign rsp_frame_index = out_res_ff.frame;
   assign rsp_tile_out    = out_tile_ff;
   assign rsp_finished    = out_res_ff.finished;

endmodule
`default_nettype wire

// File: rtl/sfs_frame_ram.sv
// sfs_frame_ram: frame tile table, one write and one registered read port
// write-first on a same-entry collision; depends on sfs_pkg
`default_nettype none
module sfs_frame_ram (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [sfs_pkg::FRAME_W-1:0]   wr_addr,
   input  wire [sfs_pkg::TILE_W-1:0]    wr_data,
   input  wire                          rd_en,
   input  wire [sfs_pkg::FRAME_W-1:0]   rd_addr,
   output logic [sfs_pkg::TILE_W-1:0]   rd_data
);

   logic [sfs_pkg::TILE_W-1:0] mem [sfs_pkg::MAX_FRAMES];
   logic [sfs_pkg::TILE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/sfs_ctrl.sv
// sfs_ctrl: configuration registers and frame stepping state
// computes the state after each accepted word; depends on sfs_pkg
`default_nettype none
module sfs_ctrl (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_we,
   input  wire [sfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [sfs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire                               accept,
   input  wire [1:0]                         action,
   output logic [sfs_pkg::FRAME_W-1:0]       frame_next,
   output sfs_pkg::result_type               result
);

   logic                         active_ff;
   logic [sfs_pkg::TICKS_W-1:0]  ticks_ff;
   logic [sfs_pkg::COUNT_W-1:0]  count_ff;
   logic [1:0]                   mode_ff;

   logic [sfs_pkg::TICKS_W-1:0]  prescale_ff, prescale_in;
   logic [sfs_pkg::FRAME_W-1:0]  frame_ff, frame_in;
   logic                         back_ff, back_in;
   logic                         done_ff, done_in;
   logic                         changed_ff, changed_in;
   logic                         adv;

   logic [sfs_pkg::COUNT_W-1:0]  n;
   logic [sfs_pkg::COUNT_W-1:0]  f1;
   logic [sfs_pkg::COUNT_W-1:0]  n_less2;
   logic [sfs_pkg::TICKS_W-1:0]  reload;
   logic                         start;
   sfs_pkg::action_type          act;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ticks_ff  <= sfs_pkg::TICKS_W'(1);
         count_ff  <= '0;
         mode_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sfs_pkg::CSR_SEQ_ACTIVE:      active_ff <= csr_wdata[0];
            sfs_pkg::CSR_TICKS_PER_FRAME: ticks_ff  <= csr_wdata;
            sfs_pkg::CSR_FRAME_COUNT:     count_ff  <= csr_wdata[sfs_pkg::COUNT_W-1:0];
            sfs_pkg::CSR_PLAY_MODE:       mode_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      act     = sfs_pkg::action_type'(action);
      n       = (count_ff > sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES)) ?
                sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES) : count_ff;
      f1      = {1'b0, frame_ff} + sfs_pkg::COUNT_W'(1);
      n_less2 = n - sfs_pkg::COUNT_W'(2);
      reload  = (!active_ff || ticks_ff == '0) ? sfs_pkg::TICKS_W'(1) : ticks_ff;
      start   = (act == sfs_pkg::ACT_RESTART) ||
                ((act == sfs_pkg::ACT_PLAY) && (done_ff || changed_ff));

      prescale_in = prescale_ff;
      frame_in    = frame_ff;
      back_in     = back_ff;
      done_in     = done_ff;
      changed_in  = changed_ff;
      adv         = 1'b0;

      if (accept) begin
         if (start) begin
            frame_in    = '0;
            prescale_in = reload;
            back_in     = 1'b0;
            done_in     = 1'b0;
            changed_in  = 1'b0;
         end else if (act == sfs_pkg::ACT_TICK && active_ff && n != '0 && !done_ff) begin
            if (prescale_ff > sfs_pkg::TICKS_W'(1)) begin
               prescale_in = prescale_ff - sfs_pkg::TICKS_W'(1);
            end else begin
               prescale_in = reload;
               adv         = 1'b1;
               if (mode_ff[1]) begin
                  if (!back_ff) begin
                     if (f1 >= n) begin
                        frame_in = (n > sfs_pkg::COUNT_W'(1)) ?
                                   n_less2[sfs_pkg::FRAME_W-1:0] : '0;
                        back_in  = 1'b1;
                     end else begin
                        frame_in = f1[sfs_pkg::FRAME_W-1:0];
                     end
                  end else if (frame_ff == '0) begin
                     frame_in = (n > sfs_pkg::COUNT_W'(1)) ? sfs_pkg::FRAME_W'(1) : '0;
                     back_in  = 1'b0;
                  end else begin
                     frame_in = frame_ff - sfs_pkg::FRAME_W'(1);
                  end
               end else if (mode_ff == sfs_pkg::MODE_LOOP) begin
                  frame_in = (f1 >= n) ? '0 : f1[sfs_pkg::FRAME_W-1:0];
               end else begin
                  if (f1 < n) begin
                     frame_in = f1[sfs_pkg::FRAME_W-1:0];
                  end else begin
                     done_in = 1'b1;
                     adv     = 1'b0;
                  end
               end
            end
         end
      end

      if (csr_we && csr_index <= sfs_pkg::CSR_PLAY_MODE) begin
         changed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= sfs_pkg::TICKS_W'(1);
         frame_ff    <= '0;
         back_ff     <= 1'b0;
         done_ff     <= 1'b0;
         changed_ff  <= 1'b1;
      end else begin
         prescale_ff <= prescale_in;
         frame_ff    <= frame_in;
         back_ff     <= back_in;
         done_ff     <= done_in;
         changed_ff  <= changed_in;
      end
   end

   always_comb begin
      frame_next       = frame_in;
      result.advanced  = adv;
      result.frame     = frame_in;
      result.finished  = done_in;
      result.tile_zero = !active_ff || (n == '0);
   end

endmodule
`default_nettype wire

// File: rtl/sfs_checker.sv
// sfs_checker: port-level assertions for the sprite frame sequencer
// bound to sprite_frame_sequencer; no package dependency
`default_nettype none
module sfs_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_stall,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire       rsp_advanced,
   input wire [3:0] rsp_frame_index,
   input wire [7:0] rsp_tile_out,
   input wire       rsp_finished
);

   // a stalled word stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_frame_index) && $stable(rsp_tile_out)
                                 && $stable(rsp_advanced) && $stable(rsp_finished))
      else $error("rsp payload changed while stalled");

   // a finished sequence never advances
   a_adv_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_advanced && rsp_finished))
      else $error("advance reported on a finished sequence");

   // pipeline empty straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);
`default_nettype wire
